// ===== sv/radix_word_dump_formatter_defines.svh =====
// Assertion macros used by the radix word dump formatter checker.
`ifndef RADIX_WORD_DUMP_FORMATTER_DEFINES_SVH
`define RADIX_WORD_DUMP_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RWDF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwdf check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RWDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwdf check failed: next-cycle rule");

`endif

// ===== sv/rwdf_pkg.sv =====
// Types, constants and lookup functions of the radix word dump formatter.
`timescale 1ns / 1ps

package rwdf_pkg;

    localparam int WORD_W             = 32;
    localparam int CHAR_W             = 8;
    localparam int RADIX_W            = 5;
    localparam int WSC_W              = 2;
    localparam int WPL_W              = 12;
    localparam int MAX_WORDS_PER_LINE = 2048;
    localparam int WON_W              = $clog2(MAX_WORDS_PER_LINE);
    localparam int LEN_W              = $clog2(MAX_WORDS_PER_LINE + 1);
    localparam int DIGIT_W            = 4;
    localparam int MAX_DIGITS         = 32;
    localparam int DCNT_W             = $clog2(MAX_DIGITS + 1);
    localparam int BYTE_W             = 8;
    localparam int BIDX_W             = $clog2(WORD_W / BYTE_W);
    localparam int DIGS_W             = MAX_DIGITS * DIGIT_W;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_SIZE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_LINE = 2'd2;

    localparam logic [WSC_W-1:0] WSC_8  = 2'd0;
    localparam logic [WSC_W-1:0] WSC_16 = 2'd1;
    localparam logic [WSC_W-1:0] WSC_32 = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd8;
    localparam logic [WSC_W-1:0]   WSC_RESET   = WSC_16;
    localparam logic [WPL_W-1:0]   WPL_RESET   = 12'd8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'd102;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              end_of_data;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SPACE,
        ST_DIGITS,
        ST_NEWLINE
    } state_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN)
            e = RADIX_MIN;
        else if (r > RADIX_MAX)
            e = RADIX_MAX;
        else
            e = r;
        return e;
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [WSC_W-1:0] wsc);
        logic [WORD_W-1:0] m;
        case (wsc)
            WSC_8:   m = 32'h0000_00FF;
            WSC_16:  m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [BIDX_W-1:0] top_byte(input logic [WSC_W-1:0] wsc);
        logic [BIDX_W-1:0] t;
        case (wsc)
            WSC_8:   t = 2'd0;
            WSC_16:  t = 2'd1;
            default: t = 2'd3;
        endcase
        return t;
    endfunction

    // Digits of the all-ones word of each size, per effective radix.
    function automatic logic [DCNT_W-1:0] digit_count(input logic [RADIX_W-1:0] base,
                                                      input logic [WSC_W-1:0] wsc);
        logic [DCNT_W-1:0] d8;
        logic [DCNT_W-1:0] d16;
        logic [DCNT_W-1:0] d32;
        logic [DCNT_W-1:0] n;
        case (base)
            5'd2:    begin d8 = 6'd8; d16 = 6'd16; d32 = 6'd32; end
            5'd3:    begin d8 = 6'd6; d16 = 6'd11; d32 = 6'd21; end
            5'd4:    begin d8 = 6'd4; d16 = 6'd8;  d32 = 6'd16; end
            5'd5:    begin d8 = 6'd4; d16 = 6'd7;  d32 = 6'd14; end
            5'd6:    begin d8 = 6'd4; d16 = 6'd7;  d32 = 6'd13; end
            5'd7:    begin d8 = 6'd3; d16 = 6'd6;  d32 = 6'd12; end
            5'd8:    begin d8 = 6'd3; d16 = 6'd6;  d32 = 6'd11; end
            5'd9:    begin d8 = 6'd3; d16 = 6'd6;  d32 = 6'd11; end
            5'd10:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd10; end
            5'd11:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd10; end
            5'd12:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd9;  end
            5'd13:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd9;  end
            5'd14:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd9;  end
            5'd15:   begin d8 = 6'd3; d16 = 6'd5;  d32 = 6'd9;  end
            default: begin d8 = 6'd2; d16 = 6'd4;  d32 = 6'd8;  end
        endcase
        case (wsc)
            WSC_8:   n = d8;
            WSC_16:  n = d16;
            default: n = d32;
        endcase
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= 4'd9)
            c = CHAR_ZERO + {4'd0, d};
        else
            c = CHAR_LOWER_A + {4'd0, d - 4'd10};
        return c;
    endfunction

endpackage

// ===== sv/rwdf_div_step.sv =====
// Shared divide unit: one byte of a long division by the radix per cycle.
`timescale 1ns / 1ps

module rwdf_div_step
    import rwdf_pkg::*;
(
    input  logic [DIGIT_W-1:0] rem_in,
    input  logic [BYTE_W-1:0]  dividend,
    input  logic [RADIX_W-1:0] base,
    output logic [BYTE_W-1:0]  quotient,
    output logic [DIGIT_W-1:0] rem_out
);

    always_comb
    begin
        logic [RADIX_W-1:0] r;
        r = {1'b0, rem_in};
        quotient = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            r = {r[DIGIT_W-1:0], dividend[i]};
            if (r >= base)
            begin
                r = r - base;
                quotient[i] = 1'b1;
            end
        end
        rem_out = r[DIGIT_W-1:0];
    end

endmodule

// ===== sv/rwdf_out_stage.sv =====
// Output register that holds one character beat until it is taken.
`timescale 1ns / 1ps

module rwdf_out_stage
    import rwdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  out_t load_item,
    output logic can_load,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    logic valid_reg;
    logic valid_next;
    out_t item_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

endmodule

// ===== sv/radix_word_dump_formatter.sv =====
// Radix word dump formatter: sequencer, configuration and divide datapath.
// Per word: accept, divide (D digits, B word bytes), send C characters.
// The divide loop runs the shared unit once per byte per digit.
// Characters (2 to 34) leave one per cycle while out_ready stays high.
// rst_n clears the line count, the sequencer and config to 8, 16-bit, 8.
`timescale 1ns / 1ps

module radix_word_dump_formatter
    import rwdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [RADIX_W-1:0] radix_reg;
    logic [WSC_W-1:0]   wsc_reg;
    logic [WPL_W-1:0]   wpl_reg;

    state_t             state_reg,    state_next;
    logic [WON_W-1:0]   won_reg,      won_next;
    logic [WORD_W-1:0]  work_reg,     work_next;
    logic [DIGIT_W-1:0] rem_reg,      rem_next;
    logic [DIGS_W-1:0]  digs_reg,     digs_next;
    logic [BIDX_W-1:0]  bidx_reg,     bidx_next;
    logic [BIDX_W-1:0]  tbyte_reg,    tbyte_next;
    logic [DCNT_W-1:0]  dcnt_reg,     dcnt_next;
    logic [DCNT_W-1:0]  ndig_reg,     ndig_next;
    logic [RADIX_W-1:0] base_reg,     base_next;
    logic               space_reg,    space_next;
    logic               nl_reg,       nl_next;

    logic               accept;
    logic [RADIX_W-1:0] base_eff;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   won_plus;
    logic               nl_now;
    logic [BYTE_W-1:0]  div_byte;
    logic [BYTE_W-1:0]  div_quot;
    logic [DIGIT_W-1:0] div_rem;
    logic [4:0]         byte_pos;
    logic               load;
    out_t               load_item;
    logic               can_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    assign base_eff = eff_radix(radix_reg);
    assign won_plus = {1'b0, won_reg} + LEN_W'(1);
    assign nl_now   = (won_plus >= len_eff) || in_item.end_of_data;
    assign byte_pos = {bidx_reg, 3'b000};
    assign div_byte = work_reg[byte_pos +: BYTE_W];

    always_comb
    begin
        if (wpl_reg == '0)
            len_eff = LEN_W'(1);
        else if (wpl_reg > WPL_W'(MAX_WORDS_PER_LINE))
            len_eff = LEN_W'(MAX_WORDS_PER_LINE);
        else
            len_eff = wpl_reg[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            wsc_reg   <= WSC_RESET;
            wpl_reg   <= WPL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:          radix_reg <= cfg_data[RADIX_W-1:0];
                CFG_WORD_SIZE:      wsc_reg   <= cfg_data[WSC_W-1:0];
                CFG_WORDS_PER_LINE: wpl_reg   <= cfg_data[WPL_W-1:0];
                default:            ;
            endcase
        end
    end

    rwdf_div_step u_div (
        .rem_in   (rem_reg),
        .dividend (div_byte),
        .base     (base_reg),
        .quotient (div_quot),
        .rem_out  (div_rem)
    );

    rwdf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_item (load_item),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always_comb
    begin
        state_next = state_reg;
        won_next   = won_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        digs_next  = digs_reg;
        bidx_next  = bidx_reg;
        tbyte_next = tbyte_reg;
        dcnt_next  = dcnt_reg;
        ndig_next  = ndig_reg;
        base_next  = base_reg;
        space_next = space_reg;
        nl_next    = nl_reg;
        load       = 1'b0;
        load_item  = '{text_char: CHAR_NEWLINE, last_char: 1'b1};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    work_next  = in_item.data_word & word_mask(wsc_reg);
                    base_next  = base_eff;
                    ndig_next  = digit_count(base_eff, wsc_reg);
                    tbyte_next = top_byte(wsc_reg);
                    bidx_next  = top_byte(wsc_reg);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    space_next = (won_reg != '0);
                    nl_next    = nl_now;
                    won_next   = nl_now ? '0 : won_plus[WON_W-1:0];
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                work_next[byte_pos +: BYTE_W] = div_quot;
                if (bidx_reg == '0)
                begin
                    digs_next = {div_rem, digs_reg[DIGS_W-1:DIGIT_W]};
                    rem_next  = '0;
                    bidx_next = tbyte_reg;
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg + DCNT_W'(1) == ndig_reg)
                    begin
                        dcnt_next  = ndig_reg;
                        state_next = space_reg ? ST_SPACE : ST_DIGITS;
                    end
                end
                else
                begin
                    rem_next  = div_rem;
                    bidx_next = bidx_reg - BIDX_W'(1);
                end
            end

            ST_SPACE:
            begin
                load_item = '{text_char: CHAR_SPACE, last_char: 1'b0};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_DIGITS;
                end
            end

            ST_DIGITS:
            begin
                load_item = '{text_char: digit_char(digs_reg[DIGS_W-1 -: DIGIT_W]),
                              last_char: (dcnt_reg == DCNT_W'(1)) && !nl_reg};
                if (can_load)
                begin
                    load      = 1'b1;
                    digs_next = digs_reg << DIGIT_W;
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1))
                        state_next = nl_reg ? ST_NEWLINE : ST_IDLE;
                end
            end

            ST_NEWLINE:
            begin
                load_item = '{text_char: CHAR_NEWLINE, last_char: 1'b1};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            won_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            won_reg   <= won_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        digs_reg  <= digs_next;
        bidx_reg  <= bidx_next;
        tbyte_reg <= tbyte_next;
        dcnt_reg  <= dcnt_next;
        ndig_reg  <= ndig_next;
        base_reg  <= base_next;
        space_reg <= space_next;
        nl_reg    <= nl_next;
    end

endmodule

// ===== sv/rwdf_checker.sv =====
// Port-level checker of the radix word dump formatter, bound to the top level.
`timescale 1ns / 1ps
`include "radix_word_dump_formatter_defines.svh"

module rwdf_checker
    import rwdf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_item
);

    logic in_beat;
    logic out_beat;
    logic is_digit;
    logic last_kind_ok;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign is_digit = ((out_item.text_char >= CHAR_ZERO) && (out_item.text_char <= CHAR_NINE))
                   || ((out_item.text_char >= CHAR_LOWER_A)
                       && (out_item.text_char <= CHAR_LOWER_F));
    assign last_kind_ok = (out_item.text_char == CHAR_NEWLINE) || is_digit;

    `RWDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `RWDF_ASSERT_NEXT(a_busy_after_in, in_beat, !in_ready)
    `RWDF_ASSERT_IMPLY(a_last_kind, out_beat && out_item.last_char, last_kind_ok)
    `RWDF_ASSERT_IMPLY(a_idle_only_last, in_ready && out_valid, out_item.last_char)

endmodule

bind radix_word_dump_formatter rwdf_checker u_rwdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
